// ===== rtl/core/ccftp_pkg.sv =====
// Package for the three-point circle center block.
// Holds payload structs, widths and the per-cell carry type; no dependencies.
package ccftp_pkg;

	localparam int CoordWidth = 16;
	localparam int DiffWidth  = CoordWidth + 1;
	localparam int SumWidth   = CoordWidth + 1;
	localparam int ProdWidth  = DiffWidth + SumWidth;
	localparam int EWidth     = ProdWidth + 1;
	localparam int DenWidth   = 2 * DiffWidth + 1;
	localparam int NumWidth   = EWidth + DiffWidth + 1;
	localparam int DivWidth   = DenWidth + 1;
	localparam int QuotBits   = 15;
	localparam int CenterLimit = 32767;

	typedef struct packed {
		logic signed [CoordWidth-1:0] first_x;
		logic signed [CoordWidth-1:0] first_y;
		logic signed [CoordWidth-1:0] second_x;
		logic signed [CoordWidth-1:0] second_y;
		logic signed [CoordWidth-1:0] third_x;
		logic signed [CoordWidth-1:0] third_y;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
	} out_item_t;

	// One axis as it moves along the divider row.
	typedef struct packed {
		logic [NumWidth-1:0]  rem;
		logic [QuotBits-1:0]  quot;
		logic                 neg;
		logic                 ok;
	} axis_t;

	// What one divider cell hands to its neighbor.
	typedef struct packed {
		logic               valid;
		logic [DivWidth-1:0] dv;
		axis_t              ax;
		axis_t              ay;
	} carry_t;

endpackage

// ===== rtl/core/circle_center_from_three_points_top.sv =====
// Top level of the three-point circle center block.
// Depends on ccftp_pkg, ccftp_front and ccftp_cell.

// Takes one point triple per cycle and returns one result per triple, in order,
// through five arithmetic stages, fifteen divider cells that each settle one
// quotient bit of both axes, and one output register.
// The whole pipeline advances together and holds when the output register is
// full and not taken, so upstream stalls only while the output is back-pressured.
// found is 0, with a zero center, for collinear points or a center outside +-32767.
module circle_center_from_three_points_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ccftp_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ccftp_pkg::out_item_t out_data
);

	localparam int NC = ccftp_pkg::QuotBits;

	ccftp_pkg::carry_t chain [NC+1];
	ccftp_pkg::carry_t last;
	logic en;
	logic okb;

	// Advance whenever the output register can take what the row produces.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	ccftp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.in_item (in_data),
		.down    (chain[0])
	);

	// Divider row, most significant quotient bit first.
	for (genvar i = 0; i < NC; i++) begin : g_cell
		ccftp_pkg::carry_t held;
		ccftp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bit_sel(4'(NC - 1 - i)),
			.up     (held),
			.down   (chain[i+1])
		);
		// A stalled row recirculates: feed back the cell's own output.
		always_comb begin
			held = chain[i];
			if (!en) begin
				held = chain[i+1];
				held.ax.rem = chain[i+1].ax.rem;
			end
		end
	end

	assign last = chain[NC];
	assign okb  = last.ax.ok && last.ay.ok;

	// Output register with signs applied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.found <= okb;
			out_data.center_x <= !okb ? 16'sd0 : (last.ax.neg ?
				-$signed({1'b0, last.ax.quot}) : $signed({1'b0, last.ax.quot}));
			out_data.center_y <= !okb ? 16'sd0 : (last.ay.neg ?
				-$signed({1'b0, last.ay.quot}) : $signed({1'b0, last.ay.quot}));
		end
	end

endmodule

// ===== rtl/core/ccftp_cell.sv =====
// One restoring-division cell: retires one quotient bit of both axes.
// Depends on ccftp_pkg.
module ccftp_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          bit_sel,
	input  ccftp_pkg::carry_t   up,
	output ccftp_pkg::carry_t   down
);

	ccftp_pkg::carry_t nxt;
	logic [ccftp_pkg::NumWidth-1:0] trial;

	// Shifted divisor for this bit position, then a compare and subtract per axis.
	always_comb begin
		trial = ccftp_pkg::NumWidth'(up.dv) << bit_sel;
		nxt = up;
		if (up.ax.rem >= trial) begin
			nxt.ax.rem = up.ax.rem - trial;
			nxt.ax.quot[bit_sel] = 1'b1;
		end
		if (up.ay.rem >= trial) begin
			nxt.ay.rem = up.ay.rem - trial;
			nxt.ay.quot[bit_sel] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down <= '0;
		end else begin
			down <= nxt;
		end
	end

endmodule

// ===== rtl/core/ccftp_front.sv =====
// Front stages: differences, bisector constants, determinant, numerators,
// range check. Depends on ccftp_pkg.
module ccftp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  ccftp_pkg::in_item_t in_item,
	output ccftp_pkg::carry_t   down
);

	localparam int DW = ccftp_pkg::DiffWidth;
	localparam int EW = ccftp_pkg::EWidth;
	localparam int NW = ccftp_pkg::NumWidth;
	localparam int VW = ccftp_pkg::DivWidth;
	localparam int PW = ccftp_pkg::DenWidth;

	// Stage 1: differences and sums.
	logic signed [DW-1:0] a_s1, b_s1, c_s1, d_s1, sx1_s1, sy1_s1, sx2_s1, sy2_s1;
	logic v_s1;
	// Stage 2: products.
	logic signed [DW-1:0] a_s2, b_s2, c_s2, d_s2;
	logic signed [EW-1:0] e_s2, f_s2;
	logic signed [PW-1:0] den_s2;
	logic v_s2;
	// Stage 3: numerator products.
	logic signed [NW-1:0] p1_s3, p2_s3, p3_s3, p4_s3;
	logic signed [PW-1:0] den_s3;
	logic v_s3;
	// Stage 4: numerators and divisor.
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic [VW-1:0] dv_s4;
	logic den_neg_s4, nz_s4, v_s4;

	logic [NW-1:0] mx, my, lim;
	logic [PW-1:0] den_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= DW'(in_item.second_x) - DW'(in_item.first_x);
			b_s1   <= DW'(in_item.second_y) - DW'(in_item.first_y);
			c_s1   <= DW'(in_item.third_x) - DW'(in_item.second_x);
			d_s1   <= DW'(in_item.third_y) - DW'(in_item.second_y);
			sx1_s1 <= DW'(in_item.second_x) + DW'(in_item.first_x);
			sy1_s1 <= DW'(in_item.second_y) + DW'(in_item.first_y);
			sx2_s1 <= DW'(in_item.third_x) + DW'(in_item.second_x);
			sy2_s1 <= DW'(in_item.third_y) + DW'(in_item.second_y);

			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			d_s2 <= d_s1;
			e_s2 <= EW'(a_s1 * sx1_s1) + EW'(b_s1 * sy1_s1);
			f_s2 <= EW'(c_s1 * sx2_s1) + EW'(d_s1 * sy2_s1);
			den_s2 <= PW'(a_s1 * d_s1) - PW'(c_s1 * b_s1);

			p1_s3 <= NW'(d_s2 * e_s2);
			p2_s3 <= NW'(f_s2 * b_s2);
			p3_s3 <= NW'(f_s2 * a_s2);
			p4_s3 <= NW'(c_s2 * e_s2);
			den_s3 <= den_s2;

			nx_s4 <= p1_s3 - p2_s3;
			ny_s4 <= p3_s3 - p4_s3;
			dv_s4 <= {den_mag, 1'b0};
			den_neg_s4 <= den_s3[PW-1];
			nz_s4 <= (den_s3 != '0);
		end
	end

	always_comb begin
		den_mag = den_s3[PW-1] ? PW'(-den_s3) : den_s3;
	end

	// Stage 5: magnitudes and the range limit against the doubled divisor.
	always_comb begin
		mx  = nx_s4[NW-1] ? NW'(-nx_s4) : NW'(nx_s4);
		my  = ny_s4[NW-1] ? NW'(-ny_s4) : NW'(ny_s4);
		lim = NW'(dv_s4) * NW'(ccftp_pkg::CenterLimit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down <= '0;
		end else if (en) begin
			down.valid   <= v_s4;
			down.dv      <= dv_s4;
			down.ax.rem  <= mx;
			down.ax.quot <= '0;
			down.ax.neg  <= nx_s4[NW-1] ^ den_neg_s4;
			down.ax.ok   <= nz_s4 && (mx <= lim);
			down.ay.rem  <= my;
			down.ay.quot <= '0;
			down.ay.neg  <= ny_s4[NW-1] ^ den_neg_s4;
			down.ay.ok   <= nz_s4 && (my <= lim);
		end
	end

endmodule
